### design/ucbh_pkg.sv
// -----------------------------------------------------------------------------
// ucbh_pkg
// Shared widths, codes and helper functions for the UTF-8 check and byte
// histogram block.
// -----------------------------------------------------------------------------
package ucbh_pkg;

   localparam int BYTE_W      = 8;
   localparam int RATIO_W     = 16;
   localparam int Q_FRAC      = 8;
   localparam int OUT_W       = 32;
   localparam int CP_W        = 21;
   localparam int CSR_IDX_W   = 2;
   localparam int REQ_TDATA_W = 16;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 168;
   localparam int RSP_PAD_W   = RSP_TDATA_W - 4 - 5 * OUT_W;

   // item kinds
   localparam logic ACT_BYTE     = 1'b0;
   localparam logic ACT_READ     = 1'b1;
   localparam logic KIND_SUMMARY = 1'b0;
   localparam logic KIND_BIN     = 1'b1;

   // summary codes
   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_EMPTY  = 2'd1;
   localparam logic [1:0] STATUS_BINARY = 2'd2;

   localparam logic [1:0] CLS_ASCII     = 2'd0;
   localparam logic [1:0] CLS_UTF8      = 2'd1;
   localparam logic [1:0] CLS_UNKNOWN   = 2'd2;
   localparam logic [1:0] CLS_NOT_ASKED = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CTRL_RATIO = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UTF8_RATIO = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IDENTIFY   = 2'd2;

   localparam logic [RATIO_W-1:0] CTRL_RATIO_RST = 16'd26;
   localparam logic [RATIO_W-1:0] UTF8_RATIO_RST = 16'd2560;

   // byte classes
   localparam logic [7:0] CONT_MASK  = 8'hC0;
   localparam logic [7:0] CONT_PAT   = 8'h80;
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_PAT  = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_PAT  = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_PAT  = 8'hF0;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_DEL   = 8'h7F;

   // noncharacter ranges
   localparam logic [CP_W-1:0] NONCHAR_LO   = 21'h00FDD0;
   localparam logic [CP_W-1:0] NONCHAR_HI   = 21'h00FDEF;
   localparam logic [CP_W-1:0] NONCHAR_TOP  = 21'h10FFFE;
   localparam logic [CP_W-1:0] NONCHAR_MASK = 21'h10FFFE;
   localparam logic [CP_W-1:0] NONCHAR_PAT  = 21'h00FFFE;

   typedef struct packed {
      logic              bump;   // text byte: increment the bin
      logic              fresh;  // first item of a text: histogram reads as zero
      logic [BYTE_W-1:0] addr;
   } hist_req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [1:0] cls;
   } verdict_type;

   function automatic logic is_ctrl(input logic [7:0] b);
      return ((b < CHAR_SPACE) && (b != CHAR_TAB) && (b != CHAR_LF) && (b != CHAR_CR))
             || (b == CHAR_DEL);
   endfunction

   function automatic logic is_nonchar(input logic [CP_W-1:0] cp);
      return ((cp >= NONCHAR_LO) && (cp <= NONCHAR_HI))
             || (cp >= NONCHAR_TOP)
             || ((cp & NONCHAR_MASK) == NONCHAR_PAT);
   endfunction

endpackage

### design/ucbh_scan.sv
// -----------------------------------------------------------------------------
// ucbh_scan
// UTF-8 sequence tracker and text counters, updated as each text item is
// accepted.
// -----------------------------------------------------------------------------
module ucbh_scan
   import ucbh_pkg::*;
#(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   take,
   input  logic [BYTE_W-1:0]      byte_value,
   input  logic                   last,
   input  logic                   end_only,
   output logic                   text_done,
   output logic [COUNT_WIDTH-1:0] err_total,
   output logic [COUNT_WIDTH-1:0] ext_total,
   output logic [COUNT_WIDTH-1:0] ctrl_total,
   output logic [COUNT_WIDTH-1:0] byte_total
);

   logic                   text_done_ff;
   logic [1:0]             pend_ff, pend_b, pend_in;
   logic [CP_W-1:0]        cp_ff, cp_b, cp_in;
   logic [COUNT_WIDTH-1:0] err_ff, ext_ff, ctrl_ff, bt_ff;
   logic [COUNT_WIDTH-1:0] err_b, ext_b, ctrl_b, bt_b;
   logic [COUNT_WIDTH-1:0] err_in, ext_in, ctrl_in, bt_in;
   logic                   use_byte, step_err, err_hit;

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   always_comb begin
      // a new text starts from clean counts and sequence state
      err_b  = text_done_ff ? '0 : err_ff;
      ext_b  = text_done_ff ? '0 : ext_ff;
      ctrl_b = text_done_ff ? '0 : ctrl_ff;
      bt_b   = text_done_ff ? '0 : bt_ff;
      pend_b = text_done_ff ? 2'd0 : pend_ff;
      cp_b   = text_done_ff ? '0 : cp_ff;

      use_byte = !(last && end_only);
      pend_in  = pend_b;
      cp_in    = cp_b;
      step_err = 1'b0;

      if (use_byte) begin
         if (pend_b != 2'd0) begin
            if ((byte_value & CONT_MASK) == CONT_PAT) begin
               cp_in   = {cp_b[CP_W-7:0], byte_value[5:0]};
               pend_in = pend_b - 2'd1;
               if ((pend_in == 2'd0) && is_nonchar(cp_in)) begin
                  step_err = 1'b1;
               end
            end else begin
               // broken sequence: drop the byte
               pend_in  = 2'd0;
               step_err = 1'b1;
            end
         end else if (byte_value[7]) begin
            if ((byte_value & LEAD2_MASK) == LEAD2_PAT) begin
               pend_in = 2'd1;
               cp_in   = {{(CP_W-5){1'b0}}, byte_value[4:0]};
            end else if ((byte_value & LEAD3_MASK) == LEAD3_PAT) begin
               pend_in = 2'd2;
               cp_in   = {{(CP_W-4){1'b0}}, byte_value[3:0]};
            end else if ((byte_value & LEAD4_MASK) == LEAD4_PAT) begin
               pend_in = 2'd3;
               cp_in   = {{(CP_W-3){1'b0}}, byte_value[2:0]};
            end else begin
               step_err = 1'b1;
            end
         end
      end

      // an open sequence at the end of the text counts once
      err_hit = step_err || (last && (pend_in != 2'd0));

      err_in  = err_hit ? sat_inc(err_b) : err_b;
      bt_in   = use_byte ? sat_inc(bt_b) : bt_b;
      ext_in  = (use_byte && byte_value[7]) ? sat_inc(ext_b) : ext_b;
      ctrl_in = (use_byte && is_ctrl(byte_value)) ? sat_inc(ctrl_b) : ctrl_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_done_ff <= 1'b1;
         pend_ff      <= 2'd0;
         cp_ff        <= '0;
         err_ff       <= '0;
         ext_ff       <= '0;
         ctrl_ff      <= '0;
         bt_ff        <= '0;
      end else if (take) begin
         text_done_ff <= last;
         pend_ff      <= last ? 2'd0 : pend_in;
         cp_ff        <= cp_in;
         err_ff       <= err_in;
         ext_ff       <= ext_in;
         ctrl_ff      <= ctrl_in;
         bt_ff        <= bt_in;
      end
   end

   assign text_done  = text_done_ff;
   assign err_total  = err_ff;
   assign ext_total  = ext_ff;
   assign ctrl_total = ctrl_ff;
   assign byte_total = bt_ff;

endmodule

### design/ucbh_hist.sv
// -----------------------------------------------------------------------------
// ucbh_hist
// 256-bin histogram memory with a registered read, read-modify-write of the
// counted bin and forwarding of the write that overlaps the next read.
// -----------------------------------------------------------------------------
module ucbh_hist
   import ucbh_pkg::*;
#(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  hist_req_type           req,
   output logic [COUNT_WIDTH-1:0] bin_old
);

   localparam int DEPTH = 1 << BYTE_W;

   logic [COUNT_WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0]       valid_ff;
   logic [COUNT_WIDTH-1:0] mem_q_ff;
   logic                   valid_q_ff;
   hist_req_type           s1_ff;
   logic                   fwd_valid_ff;
   logic [BYTE_W-1:0]      fwd_addr_ff;
   logic [COUNT_WIDTH-1:0] fwd_data_ff;
   logic                   fwd_hit;
   logic [COUNT_WIDTH-1:0] bin_new;

   always_comb begin
      fwd_hit = fwd_valid_ff && (fwd_addr_ff == s1_ff.addr);
      if (s1_ff.fresh) begin
         bin_old = '0;
      end else if (fwd_hit) begin
         bin_old = fwd_data_ff;
      end else if (valid_q_ff) begin
         bin_old = mem_q_ff;
      end else begin
         bin_old = '0;
      end
      bin_new = (&bin_old) ? bin_old : bin_old + 1'b1;
   end

   // read before write, so the overlapping access takes the forwarded value
   always_ff @(posedge clock) begin
      if (adv) begin
         mem_q_ff <= mem[req.addr];
         if (s1_ff.bump) begin
            mem[s1_ff.addr] <= bin_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         valid_q_ff   <= 1'b0;
         s1_ff        <= '0;
         fwd_valid_ff <= 1'b0;
      end else if (adv) begin
         valid_q_ff   <= valid_ff[req.addr];
         s1_ff        <= req;
         fwd_valid_ff <= s1_ff.bump;
         // a new text clears every bin; the older write is dropped
         if (req.fresh) begin
            valid_ff <= '0;
         end else if (s1_ff.bump) begin
            valid_ff[s1_ff.addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fwd_addr_ff <= s1_ff.addr;
         fwd_data_ff <= bin_new;
      end
   end

endmodule

### design/ucbh_verdict.sv
// -----------------------------------------------------------------------------
// ucbh_verdict
// Ratio products for the binary and charset tests, registered, then
// compared into status and charset class.
// -----------------------------------------------------------------------------
module ucbh_verdict
   import ucbh_pkg::*;
#(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   load,
   input  logic [COUNT_WIDTH-1:0] err_total,
   input  logic [COUNT_WIDTH-1:0] ext_total,
   input  logic [COUNT_WIDTH-1:0] ctrl_total,
   input  logic [COUNT_WIDTH-1:0] byte_total,
   input  logic [RATIO_W-1:0]     ctrl_ratio,
   input  logic [RATIO_W-1:0]     utf8_ratio,
   input  logic                   identify_enable,
   output verdict_type            verdict
);

   localparam int PW = COUNT_WIDTH + RATIO_W;

   logic [PW-1:0] bin_prod_ff, bin_ref_ff, utf_prod_ff, utf_ref_ff;
   logic          empty_ff, ascii_ff;
   logic          binary, utf8;

   always_ff @(posedge clock) begin
      if (load) begin
         bin_prod_ff <= PW'(byte_total) * PW'(ctrl_ratio);
         bin_ref_ff  <= PW'({ctrl_total, {Q_FRAC{1'b0}}});
         utf_prod_ff <= PW'(ext_total) * PW'(utf8_ratio);
         utf_ref_ff  <= PW'({err_total, {Q_FRAC{1'b0}}});
         empty_ff    <= (byte_total == '0);
         ascii_ff    <= (ext_total == '0);
      end
   end

   always_comb begin
      binary = bin_prod_ff < bin_ref_ff;
      utf8   = utf_ref_ff < utf_prod_ff;
      verdict.cls = CLS_NOT_ASKED;
      if (empty_ff) begin
         verdict.status = STATUS_EMPTY;
      end else if (binary) begin
         verdict.status = STATUS_BINARY;
      end else begin
         verdict.status = STATUS_OK;
         if (identify_enable) begin
            if (ascii_ff) begin
               verdict.cls = CLS_ASCII;
            end else if (utf8) begin
               verdict.cls = CLS_UTF8;
            end else begin
               verdict.cls = CLS_UNKNOWN;
            end
         end
      end
   end

endmodule

### design/utf8_check_byte_histogram.sv
// -----------------------------------------------------------------------------
// utf8_check_byte_histogram
// UTF-8 structure check with a 256-bin byte histogram and a text summary.
// -----------------------------------------------------------------------------
// Usage:
//   req_* takes items. A text item (tuser action 0) carries one byte; tlast
//   ends the text and produces a summary; tlast with end_only ends the text
//   with no byte. A read item (action 1) returns the bin named by bin_index.
//   The first text item after a summary or reset starts a new text: the
//   counts and the histogram read as zero from then on.
//   rsp_* carries one item per summary or bin read; tuser gives its kind.
//   csr_* writes ctrl_ratio (0), utf8_ratio (1) and identify_enable (2);
//   write only while no item is in flight. csr_ready is always high.
// Timing:
//   One item per cycle unless stalled. Results pass stage 1, stage 2 and
//   the output register. The pace is set by the histogram memory: one read
//   and one write per cycle, the write of one byte forwarded to the next read.
// Reset:
//   Clears the bin valid bits, counts and pipeline; registers return to
//   26, 2560 and 1. No clearing pass is needed.
// Stall:
//   A stalled rsp_tready holds the output register; the two stages before it
//   keep filling, and req_tready drops only when a result has nowhere to go.
// -----------------------------------------------------------------------------
module utf8_check_byte_histogram
   import ucbh_pkg::*;
#(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // byte_value[7:0], bin_index[15:8]
   input  logic [REQ_TUSER_W-1:0] req_tuser,   // action[0], end_only[1]
   input  logic                   req_tlast,   // last
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // status[1:0], charset_class[3:2], utf8_errors[35:4], ext_count[67:36],
   // ctrl_count[99:68], total_bytes[131:100], bin_count[163:132], zero pad
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tuser,   // kind
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [RATIO_W-1:0]     csr_data
);

   logic [RATIO_W-1:0]     ctrl_ratio_ff, utf8_ratio_ff;
   logic                   identify_ff;

   logic                   accept, is_text;
   logic [BYTE_W-1:0]      byte_value, bin_index;
   logic                   action, end_only;
   hist_req_type           hreq;

   logic                   text_done;
   logic [COUNT_WIDTH-1:0] err_total, ext_total, ctrl_total, byte_total;
   logic [COUNT_WIDTH-1:0] bin_old;

   logic                   s1_res_ff, s1_kind_ff;
   logic                   s2_res_ff, s2_kind_ff;
   logic [OUT_W-1:0]       s2_err_ff, s2_ext_ff, s2_ctrl_ff, s2_bt_ff, s2_bin_ff;
   logic                   out_free, s2_free, front_adv;
   verdict_type            verdict;

   logic                   rsp_tvalid_ff, rsp_tuser_ff;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   function automatic logic [OUT_W-1:0] clip_out(input logic [COUNT_WIDTH-1:0] v);
      logic [63:0] w;
      w = 64'(v);
      return (w > 64'hFFFF_FFFF) ? '1 : w[OUT_W-1:0];
   endfunction

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ratio_ff <= CTRL_RATIO_RST;
         utf8_ratio_ff <= UTF8_RATIO_RST;
         identify_ff   <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CTRL_RATIO: ctrl_ratio_ff <= csr_data;
            CSR_UTF8_RATIO: utf8_ratio_ff <= csr_data;
            CSR_IDENTIFY:   identify_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   // flow control: stall the front only when a result cannot move on
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign s2_free    = !s2_res_ff || out_free;
   assign front_adv  = !s1_res_ff || s2_free;
   assign req_tready = front_adv;

   assign accept     = req_tvalid && req_tready;
   assign byte_value = req_tdata[7:0];
   assign bin_index  = req_tdata[15:8];
   assign action     = req_tuser[0];
   assign end_only   = req_tuser[1];
   assign is_text    = accept && (action == ACT_BYTE);

   always_comb begin
      hreq.addr  = (action == ACT_READ) ? bin_index : byte_value;
      hreq.bump  = is_text && !(req_tlast && end_only);
      hreq.fresh = is_text && text_done;
   end

   ucbh_scan #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .take       (is_text),
      .byte_value (byte_value),
      .last       (req_tlast),
      .end_only   (end_only),
      .text_done  (text_done),
      .err_total  (err_total),
      .ext_total  (ext_total),
      .ctrl_total (ctrl_total),
      .byte_total (byte_total)
   );

   ucbh_hist #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_hist (
      .clock   (clock),
      .reset   (reset),
      .adv     (front_adv),
      .req     (hreq),
      .bin_old (bin_old)
   );

   // stage 1: memory data returns; counts still hold the summary snapshot
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_res_ff  <= 1'b0;
         s1_kind_ff <= KIND_SUMMARY;
      end else if (front_adv) begin
         s1_res_ff  <= accept && ((action == ACT_READ) || req_tlast);
         s1_kind_ff <= (action == ACT_READ) ? KIND_BIN : KIND_SUMMARY;
      end
   end

   // stage 2: products and clipped fields
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_res_ff  <= 1'b0;
         s2_kind_ff <= KIND_SUMMARY;
      end else if (s2_free) begin
         s2_res_ff  <= s1_res_ff;
         s2_kind_ff <= s1_kind_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_free) begin
         s2_err_ff  <= clip_out(err_total);
         s2_ext_ff  <= clip_out(ext_total);
         s2_ctrl_ff <= clip_out(ctrl_total);
         s2_bt_ff   <= clip_out(byte_total);
         s2_bin_ff  <= clip_out(bin_old);
      end
   end

   ucbh_verdict #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_verdict (
      .clock           (clock),
      .load            (s2_free),
      .err_total       (err_total),
      .ext_total       (ext_total),
      .ctrl_total      (ctrl_total),
      .byte_total      (byte_total),
      .ctrl_ratio      (ctrl_ratio_ff),
      .utf8_ratio      (utf8_ratio_ff),
      .identify_enable (identify_ff),
      .verdict         (verdict)
   );

   // output register
   always_comb begin
      if (s2_kind_ff == KIND_BIN) begin
         rsp_tdata_in = {{RSP_PAD_W{1'b0}}, s2_bin_ff, {(4 * OUT_W + 4){1'b0}}};
      end else begin
         rsp_tdata_in = {{RSP_PAD_W{1'b0}}, {OUT_W{1'b0}}, s2_bt_ff, s2_ctrl_ff,
                         s2_ext_ff, s2_err_ff, verdict.cls, verdict.status};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_tvalid_ff <= s2_res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_tuser_ff <= s2_kind_ff;
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

### design/ucbh_checker.sv
// -----------------------------------------------------------------------------
// ucbh_checker
// Port-level checks on the result channel of the UTF-8 check block.
// -----------------------------------------------------------------------------
module ucbh_checker
   import ucbh_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic                   rsp_tuser
);

   logic summary, bin_read;

   assign summary  = rsp_tvalid && (rsp_tuser == KIND_SUMMARY);
   assign bin_read = rsp_tvalid && (rsp_tuser == KIND_BIN);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_bin_zero: assert property (@(posedge clock) disable iff (reset)
      bin_read |-> (rsp_tdata[131:0] == '0) && (rsp_tdata[167:164] == '0))
      else $error("bin read carries summary fields");

   a_sum_fields: assert property (@(posedge clock) disable iff (reset)
      summary |-> (rsp_tdata[167:132] == '0) && (rsp_tdata[1:0] != 2'd3))
      else $error("summary carries a bin count or a bad status");

   a_cls_asked: assert property (@(posedge clock) disable iff (reset)
      summary && (rsp_tdata[1:0] != STATUS_OK) |-> (rsp_tdata[3:2] == CLS_NOT_ASKED))
      else $error("verdict given for an empty or binary text");

   a_empty: assert property (@(posedge clock) disable iff (reset)
      summary && (rsp_tdata[1:0] == STATUS_EMPTY) |-> (rsp_tdata[131:4] == '0))
      else $error("empty text with nonzero counts");

endmodule

bind utf8_check_byte_histogram ucbh_checker u_checker (.*);
